// ===== sv/assert_macros.svh =====
// Assertion macros for the alphabet radix converter RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted (active low).
`define ARC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("arc: same-cycle implication violated");
// Next-cycle implication, disabled while reset is asserted (active low).
`define ARC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("arc: next-cycle implication violated");
`else
`define ARC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define ARC_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== sv/arc_pkg.sv =====
// Shared types, constants and helper functions for the alphabet radix converter.
// No dependencies; imported by every module of the block.
`default_nettype none
package arc_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int MAX_SYMBOLS = 16;
  localparam int STORE_DEPTH = VALUE_BITS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(VALUE_BITS + 1);
  localparam int ITER_W      = $clog2(VALUE_BITS);
  localparam int BASE_W      = 5;
  localparam int DIGIT_W     = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [63:0] ALPHA_RESET_LOW  = 64'd3978425819141910832;
  localparam logic [63:0] ALPHA_RESET_HIGH = 64'd5063528411713059128;
  localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_BASE   = 3'd5;

  typedef struct packed {
    logic [7:0] digit_char;
    logic       last_digit;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_t;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_W-1:0]    remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_RD   = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < 5'd2) r = 5'd2;
    else if (b > 5'(MAX_SYMBOLS)) r = 5'(MAX_SYMBOLS);
    else r = b;
    return r;
  endfunction

  function automatic logic [7:0] symbol_of(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [3:0] k);
    logic [63:0] word;
    word = k[3] ? hi : lo;
    return word[{k[2:0], 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

// ===== sv/arc_divider.sv =====
// Iterative restoring divider: one quotient bit per cycle, VALUE_BITS quotient bits per division.
// Depends on arc_pkg for widths and the request/response structs.
`default_nettype none
module arc_divider
  import arc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire div_req_t          req,
  input  wire logic [BASE_W-1:0] divisor,
  output div_rsp_t               rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [ITER_W-1:0]     iter_r, iter_nxt;
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [BASE_W-1:0]     trial;
  logic                  fits;

  assign trial = {rem_r, q_r[VALUE_BITS-1]};
  assign fits  = (trial >= divisor);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      q_nxt    = req.dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift in one quotient bit, keep the partial remainder below the divisor
      q_nxt    = {q_r[VALUE_BITS-2:0], fits};
      rem_nxt  = fits ? DIGIT_W'(trial - divisor) : trial[DIGIT_W-1:0];
      iter_nxt = iter_r + 1'b1;
      if (iter_r == ITER_W'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = q_r;
  assign rsp.remainder = rem_r;

endmodule
`default_nettype wire

// ===== sv/arc_digit_store.sv =====
// Digit store: STORE_DEPTH x DIGIT_W memory, one write port, one registered read port.
// Depends on arc_pkg for depth and widths.
`default_nettype none
module arc_digit_store
  import arc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire logic [DIGIT_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output logic      [DIGIT_W-1:0] rd_data
);

  logic [DIGIT_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/alphabet_radix_converter_top.sv =====
// A digit without the last mark is folded into the accumulator and taken back to back.
// The last digit runs the shared bit-serial divider once per target digit, then each
// emitted character takes a registered store read (S_RD) and then output (S_EMIT),
// which holds while out_stall is high.
// Reset (rst_n low, synchronous): alphabets "0123456789ABCDEF", bases 10, value 0.
// Depends on arc_pkg, arc_divider, arc_digit_store and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module alphabet_radix_converter_top
  import arc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [63:0]       from_low_r, from_high_r, to_low_r, to_high_r;
  logic [BASE_W-1:0] from_base_r, to_base_r;
  logic [BASE_W-1:0] fb, tb;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  logic                     in_fire;
  logic [BASE_W-1:0]        digit_val;
  logic [VALUE_BITS+4:0]    prod;
  logic [VALUE_BITS-1:0]    horner;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               st_wr_en, st_rd_en;
  logic [ADDR_W-1:0]  st_rd_addr;
  logic [DIGIT_W-1:0] st_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_low_r  <= ALPHA_RESET_LOW;
      from_high_r <= ALPHA_RESET_HIGH;
      from_base_r <= BASE_RESET;
      to_low_r    <= ALPHA_RESET_LOW;
      to_high_r   <= ALPHA_RESET_HIGH;
      to_base_r   <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FROM_LOW:  from_low_r  <= cfg_data;
        CFG_FROM_HIGH: from_high_r <= cfg_data;
        CFG_FROM_BASE: from_base_r <= cfg_data[BASE_W-1:0];
        CFG_TO_LOW:    to_low_r    <= cfg_data;
        CFG_TO_HIGH:   to_high_r   <= cfg_data;
        CFG_TO_BASE:   to_base_r   <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign fb = clamp_base(from_base_r);
  assign tb = clamp_base(to_base_r);

  // lowest matching symbol wins; no match yields the base itself
  always_comb begin
    digit_val = fb;
    for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
      if ((BASE_W'(k) < fb) &&
          (symbol_of(from_low_r, from_high_r, 4'(k)) == in_data.digit_char)) begin
        digit_val = BASE_W'(k);
      end
    end
  end

  assign prod    = {5'b0, acc_r} * {{VALUE_BITS{1'b0}}, fb};
  assign horner  = prod[VALUE_BITS-1:0] + {{(VALUE_BITS-BASE_W){1'b0}}, digit_val};

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    state_nxt        = state_r;
    acc_nxt          = acc_r;
    cnt_nxt          = cnt_r;
    div_req.start    = 1'b0;
    div_req.dividend = horner;
    st_wr_en         = 1'b0;
    st_rd_en         = 1'b0;
    st_rd_addr       = ADDR_W'(cnt_r - 1'b1);
    out_valid        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.last_digit) begin
            acc_nxt       = '0;
            cnt_nxt       = '0;
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            acc_nxt = horner;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          st_wr_en = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          if ((div_rsp.quotient != '0) && (cnt_r < CNT_W'(VALUE_BITS - 1))) begin
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        st_rd_en  = 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = (cnt_r == '0) ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign out_data.out_char  = symbol_of(to_low_r, to_high_r, st_rd_data);
  assign out_data.last_char = (cnt_r == '0);

  arc_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (tb),
    .rsp     (div_rsp)
  );

  arc_digit_store u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (div_rsp.remainder),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  `ARC_ASSERT_IMP(a_no_accept_while_emit, clk, rst_n, out_valid, in_stall)
  `ARC_ASSERT_IMP(a_div_done_in_div, clk, rst_n, div_rsp.done, state_r == S_DIV)
  `ARC_ASSERT_NXT(a_last_returns_idle, clk, rst_n, out_valid && !out_stall && out_data.last_char, state_r == S_IDLE)

endmodule
`default_nettype wire
